// File: hdl/sth_pkg.sv
package sth_pkg;

   // payload widths of the request and response channels
   localparam int ACTION_BITS = 2;
   localparam int VALUE_BITS  = 4;
   localparam int INDEX_BITS  = 8;
   localparam int WEIGHT_BITS = 16;
   localparam int COUNT_OUT_BITS = 32;
   localparam int SUM_BITS    = 64;

   // request action codes
   typedef enum logic [ACTION_BITS-1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_READ   = 2'd1,
      ACT_WEIGHT = 2'd2
   } action_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SAMPLE,
      ST_READ,
      ST_MUL,
      ST_SUM,
      ST_ACC
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic sample_wr;
      logic load_read;
      logic mul;
      logic sum;
      logic acc_step;
      logic load_sum;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic                   req_valid;
      logic [ACTION_BITS-1:0] action;
      logic                   last;
      logic                   clear_done;
      logic                   out_free;
   } ctrl_status_type;

endpackage

// File: hdl/sth_if.sv
interface sth_req_if import sth_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [ACTION_BITS-1:0]        action;
   logic [VALUE_BITS-1:0]         signal_value;
   logic [INDEX_BITS-1:0]         read_index;
   logic signed [WEIGHT_BITS-1:0] weight;
   logic                          last;

   modport source (output valid, action, signal_value, read_index, weight, last,
                   input ready);
   modport sink   (input valid, action, signal_value, read_index, weight, last,
                   output ready);
endinterface

interface sth_rsp_if import sth_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [COUNT_OUT_BITS-1:0]  count_value;
   logic signed [SUM_BITS-1:0] weighted_sum;
   logic                       sum_valid;

   modport source (output valid, count_value, weighted_sum, sum_valid, input ready);
   modport sink   (input valid, count_value, weighted_sum, sum_valid, output ready);
endinterface

// File: hdl/sth_ram.sv
module sth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sth_ctrl.sv
module sth_ctrl import sth_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            req_ready
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = status.req_valid;
            if (status.req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            case (status.action)
               ACT_SAMPLE: state_in = ST_SAMPLE;
               ACT_READ:   state_in = ST_READ;
               ACT_WEIGHT: state_in = ST_MUL;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_SAMPLE: begin
            cmd.sample_wr = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            if (status.out_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // last weight waits for the response register
            if (!status.last || status.out_free) begin
               cmd.acc_step = 1'b1;
               cmd.load_sum = status.last;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: hdl/sth_datapath.sv
module sth_datapath import sth_pkg::*; #(
   parameter int SIGNAL_COUNT = 4,
   parameter int COUNT_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output ctrl_status_type               status,
   input  logic                          req_valid,
   input  logic [ACTION_BITS-1:0]        req_action,
   input  logic [VALUE_BITS-1:0]         req_signal_value,
   input  logic [INDEX_BITS-1:0]         req_read_index,
   input  logic signed [WEIGHT_BITS-1:0] req_weight,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COUNT_OUT_BITS-1:0]     rsp_count_value,
   output logic signed [SUM_BITS-1:0]    rsp_weighted_sum,
   output logic                          rsp_sum_valid
);

   localparam int ENTRY_BITS = 2 * SIGNAL_COUNT;
   localparam int DEPTH      = 1 << ENTRY_BITS;
   localparam int HALF       = (COUNT_BITS + 1) / 2;
   localparam int PAD_BITS   = 2 * HALF;
   localparam int PART_BITS  = HALF + WEIGHT_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // captured request
   logic [ACTION_BITS-1:0]        act_ff;
   logic [SIGNAL_COUNT-1:0]       cur_ff;
   logic [ENTRY_BITS-1:0]         ridx_ff;
   logic signed [WEIGHT_BITS-1:0] weight_ff;
   logic                          last_ff;

   // monitor state
   logic [SIGNAL_COUNT-1:0]    prev_ff;
   logic [ENTRY_BITS-1:0]      ptr_ff;
   logic signed [SUM_BITS-1:0] acc_ff;
   logic [ENTRY_BITS-1:0]      clear_ptr_ff;

   // multiply stages
   logic signed [PART_BITS-1:0] part_lo_ff;
   logic signed [PART_BITS-1:0] part_hi_ff;
   logic signed [PART_BITS-1:0] part_lo_in;
   logic signed [PART_BITS-1:0] part_hi_in;
   logic signed [SUM_BITS-1:0]  prod_ff;
   logic signed [SUM_BITS-1:0]  prod_in;

   // response register
   logic                       rsp_valid_ff;
   logic [COUNT_OUT_BITS-1:0]  count_value_ff;
   logic signed [SUM_BITS-1:0] weighted_sum_ff;
   logic                       sum_valid_ff;

   logic [SIGNAL_COUNT+VALUE_BITS-1:0] cur_wide;
   logic [ENTRY_BITS+INDEX_BITS-1:0]   ridx_wide;
   logic [SIGNAL_COUNT-1:0]            cur_in;
   logic [ENTRY_BITS-1:0]              ridx_in;
   logic [ENTRY_BITS-1:0]              sample_idx;

   logic                        wr_en;
   logic [ENTRY_BITS-1:0]       wr_addr;
   logic [COUNT_BITS-1:0]       wr_data;
   logic [ENTRY_BITS-1:0]       rd_addr;
   logic [COUNT_BITS-1:0]       rd_data;
   logic [COUNT_BITS-1:0]       count_inc;
   logic [PAD_BITS-1:0]         cnt_pad;
   logic [COUNT_BITS+COUNT_OUT_BITS-1:0] cnt_wide;
   logic [COUNT_OUT_BITS-1:0]   count_sat;
   logic signed [SUM_BITS:0]    acc_sum;
   logic signed [SUM_BITS-1:0]  acc_next;

   // fit request fields to the store geometry
   assign cur_wide   = {{SIGNAL_COUNT{1'b0}}, req_signal_value};
   assign ridx_wide  = {{ENTRY_BITS{1'b0}}, req_read_index};
   assign cur_in     = cur_wide[SIGNAL_COUNT-1:0];
   assign ridx_in    = ridx_wide[ENTRY_BITS-1:0];
   assign sample_idx = {prev_ff, cur_ff};

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff    <= req_action;
         cur_ff    <= cur_in;
         ridx_ff   <= ridx_in;
         weight_ff <= req_weight;
         last_ff   <= req_last;
      end
   end

   // counter store address and write data selection
   always_comb begin
      case (act_ff)
         ACT_SAMPLE: rd_addr = sample_idx;
         ACT_READ:   rd_addr = ridx_ff;
         default:    rd_addr = ptr_ff;
      endcase
      count_inc = (&rd_data) ? rd_data : rd_data + COUNT_BITS'(1);
      wr_en     = cmd.clear_wr | cmd.sample_wr;
      if (cmd.clear_wr) begin
         wr_addr = clear_ptr_ff;
         wr_data = '0;
      end else begin
         wr_addr = sample_idx;
         wr_data = count_inc;
      end
   end

   sth_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_ptr_ff <= clear_ptr_ff + ENTRY_BITS'(1);
      end
   end

   // previous sample value
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (cmd.sample_wr) begin
         prev_ff <= cur_ff;
      end
   end

   // weight times count as two half-width partial products
   assign cnt_pad    = PAD_BITS'(rd_data);
   assign part_lo_in = PART_BITS'(weight_ff) * PART_BITS'($signed({1'b0, cnt_pad[HALF-1:0]}));
   assign part_hi_in = PART_BITS'(weight_ff)
                     * PART_BITS'($signed({1'b0, cnt_pad[PAD_BITS-1:HALF]}));
   assign prod_in    = (SUM_BITS'(part_hi_ff) <<< HALF) + SUM_BITS'(part_lo_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         part_lo_ff <= part_lo_in;
         part_hi_ff <= part_hi_in;
      end
      if (cmd.sum) begin
         prod_ff <= prod_in;
      end
   end

   // saturating accumulate
   always_comb begin
      acc_sum = (SUM_BITS+1)'(acc_ff) + (SUM_BITS+1)'(prod_ff);
      if (acc_sum[SUM_BITS] != acc_sum[SUM_BITS-1]) begin
         acc_next = acc_sum[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         acc_next = acc_sum[SUM_BITS-1:0];
      end
   end

   // weight walk pointer and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.acc_step) begin
         if (last_ff) begin
            ptr_ff <= '0;
            acc_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + ENTRY_BITS'(1);
            acc_ff <= acc_next;
         end
      end
   end

   // read result saturated to the response width
   assign cnt_wide  = {{COUNT_OUT_BITS{1'b0}}, rd_data};
   assign count_sat = (|cnt_wide[COUNT_BITS+COUNT_OUT_BITS-1:COUNT_OUT_BITS])
                    ? {COUNT_OUT_BITS{1'b1}} : cnt_wide[COUNT_OUT_BITS-1:0];

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_read || cmd.load_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         count_value_ff  <= count_sat;
         weighted_sum_ff <= '0;
         sum_valid_ff    <= 1'b0;
      end else if (cmd.load_sum) begin
         count_value_ff  <= '0;
         weighted_sum_ff <= acc_next;
         sum_valid_ff    <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_value  = count_value_ff;
   assign rsp_weighted_sum = weighted_sum_ff;
   assign rsp_sum_valid    = sum_valid_ff;

   // status to controller
   assign status.req_valid  = req_valid;
   assign status.action     = act_ff;
   assign status.last       = last_ff;
   assign status.clear_done = &clear_ptr_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: hdl/signal_transition_histogram.sv
// a read response passes the request capture, the store read and the response register;
// a weighted sum passes the store read, two product stages and the accumulate
// one request at a time: a new request is taken only once the controller is back in idle;
// a read or last weight also waits while the response register is still full
// reset: synchronous; a clearing sweep writes zero to all 2^(2*SIGNAL_COUNT)
// counters (256 by default), one per cycle, before the first request
module signal_transition_histogram import sth_pkg::*; #(
   parameter int SIGNAL_COUNT = 4,
   parameter int COUNT_BITS   = 32
) (
   input logic       clock,
   input logic       reset,
   sth_req_if.sink   req_port,
   sth_rsp_if.source rsp_port
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // controller
   sth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_port.ready)
   );

   // datapath with counter store
   sth_datapath #(
      .SIGNAL_COUNT (SIGNAL_COUNT),
      .COUNT_BITS   (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_port.valid),
      .req_action       (req_port.action),
      .req_signal_value (req_port.signal_value),
      .req_read_index   (req_port.read_index),
      .req_weight       (req_port.weight),
      .req_last         (req_port.last),
      .rsp_valid        (rsp_port.valid),
      .rsp_ready        (rsp_port.ready),
      .rsp_count_value  (rsp_port.count_value),
      .rsp_weighted_sum (rsp_port.weighted_sum),
      .rsp_sum_valid    (rsp_port.sum_valid)
   );

endmodule

// File: verif/transition_histogram_checker.sv
module transition_histogram_checker import sth_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sth_req_if          req_port,
   sth_rsp_if          rsp_port,
   output int unsigned failures,
   output int unsigned outstanding
);

   localparam int ENTRIES = 1 << (2 * VALUE_BITS);
   localparam logic [COUNT_OUT_BITS-1:0] COUNT_TOP = '1;
   localparam logic signed [SUM_BITS-1:0] SUM_HIGH = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_LOW  = {1'b1, {(SUM_BITS-1){1'b0}}};

   // one response as the block should send it
   typedef struct {
      logic [COUNT_OUT_BITS-1:0]  count_value;
      logic signed [SUM_BITS-1:0] weighted_sum;
      logic                       sum_valid;
   } readout_type;

   // mirrored histogram state
   logic [COUNT_OUT_BITS-1:0]  pair_counts [ENTRIES];
   logic [VALUE_BITS-1:0]      last_value;
   logic [INDEX_BITS-1:0]      walk_entry;
   logic signed [SUM_BITS-1:0] energy;
   readout_type                due_readouts [$];
   int unsigned                mismatch_total;

   // energy sum clamped at the 64-bit bounds
   function automatic logic signed [SUM_BITS-1:0] add_clamped(
      input logic signed [SUM_BITS-1:0] a,
      input logic signed [SUM_BITS-1:0] b
   );
      logic signed [SUM_BITS+1:0] wide;
      wide = a + b;
      if (wide > SUM_HIGH) begin
         return SUM_HIGH;
      end
      if (wide < SUM_LOW) begin
         return SUM_LOW;
      end
      return wide[SUM_BITS-1:0];
   endfunction

   function automatic void note_failure(input string text);
      mismatch_total++;
      if (mismatch_total <= 10) begin
         $display("%s", text);
      end
   endfunction

   // update the mirrored counters and queue any response the request causes
   task automatic track_request();
      readout_type                reply;
      logic [INDEX_BITS-1:0]      pair;
      logic signed [SUM_BITS-1:0] product;
      case (req_port.action)
         ACT_SAMPLE: begin
            pair = {last_value, req_port.signal_value};
            if (pair_counts[pair] != COUNT_TOP) begin
               pair_counts[pair] = pair_counts[pair] + 1'b1;
            end
            last_value = req_port.signal_value;
         end
         ACT_READ: begin
            reply.count_value  = pair_counts[req_port.read_index];
            reply.weighted_sum = '0;
            reply.sum_valid    = 1'b0;
            due_readouts.push_back(reply);
         end
         ACT_WEIGHT: begin
            product = req_port.weight * $signed({1'b0, pair_counts[walk_entry]});
            energy  = add_clamped(energy, product);
            if (req_port.last) begin
               reply.count_value  = '0;
               reply.weighted_sum = energy;
               reply.sum_valid    = 1'b1;
               due_readouts.push_back(reply);
               walk_entry = '0;
               energy     = '0;
            end else begin
               // pointer wraps past the last entry
               walk_entry = walk_entry + 1'b1;
            end
         end
         default: begin
            // unused code leaves everything alone
         end
      endcase
   endtask

   // compare one response with the oldest one due
   task automatic check_readout();
      readout_type want;
      if (due_readouts.size() == 0) begin
         note_failure($sformatf("response with nothing due: count %0h sum %0d flag %0b",
                                rsp_port.count_value, rsp_port.weighted_sum,
                                rsp_port.sum_valid));
      end else begin
         want = due_readouts.pop_front();
         if (rsp_port.count_value !== want.count_value) begin
            note_failure($sformatf("count_value: expected %0h, got %0h",
                                   want.count_value, rsp_port.count_value));
         end
         if (rsp_port.weighted_sum !== want.weighted_sum) begin
            note_failure($sformatf("weighted_sum: expected %0d, got %0d",
                                   want.weighted_sum, rsp_port.weighted_sum));
         end
         if (rsp_port.sum_valid !== want.sum_valid) begin
            note_failure($sformatf("sum_valid: expected %0b, got %0b",
                                   want.sum_valid, rsp_port.sum_valid));
         end
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (pair_counts[i]) begin
            pair_counts[i] = '0;
         end
         last_value = '0;
         walk_entry = '0;
         energy     = '0;
         due_readouts.delete();
         mismatch_total = 0;
      end else begin
         if (req_port.valid && req_port.ready) begin
            track_request();
         end
         if (rsp_port.valid && rsp_port.ready) begin
            check_readout();
         end
      end
      failures    <= mismatch_total;
      outstanding <= due_readouts.size();
   end

endmodule

// File: verif/signal_transition_histogram_tb.sv
module signal_transition_histogram_tb;
   import sth_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int LIMIT_CYCLES = 600000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 320;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

   logic clock;
   logic reset;

   sth_req_if req_bus ();
   sth_rsp_if rsp_bus ();

   int unsigned failures;
   int unsigned outstanding;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned phase_items;
   int unsigned idle_plan  [4] = '{0, 88, 0, 8};
   int unsigned stall_plan [4] = '{0, 0, 88, 8};
   logic [VALUE_BITS-1:0] last_sampled;
   bit squeeze;
   bit ready_hold;

   signal_transition_histogram uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   transition_histogram_checker watcher (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // clock
   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // response side stalls, or holds off entirely while squeezed
   always @(negedge clock) begin
      if (ready_hold) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // long hold-off so the block backs up and stalls its requests
   initial begin
      ready_hold = 1'b0;
      wait (squeeze);
      @(posedge clock);
      ready_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      ready_hold = 1'b0;
   end

   // run limit
   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("signal_transition_histogram_tb: errors");
      $finish;
   end

   // offer one request from a falling edge, return on the falling edge after acceptance
   task automatic send_request(
      input logic [ACTION_BITS-1:0]        act,
      input logic [VALUE_BITS-1:0]         value,
      input logic [INDEX_BITS-1:0]         index,
      input logic signed [WEIGHT_BITS-1:0] wt,
      input logic                          fin
   );
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.signal_value <= value;
      req_bus.read_index   <= index;
      req_bus.weight       <= wt;
      req_bus.last         <= fin;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      if (act != ACT_UNUSED) begin
         phase_items++;
      end
      @(negedge clock);
   endtask

   task automatic sample_signals(input logic [VALUE_BITS-1:0] value);
      send_request(ACT_SAMPLE, value, 8'($urandom), 16'($urandom), 1'($urandom));
      last_sampled = value;
   endtask

   task automatic read_counter(input logic [INDEX_BITS-1:0] index);
      send_request(ACT_READ, 4'($urandom), index, 16'($urandom), 1'($urandom));
   endtask

   task automatic apply_weight(input logic signed [WEIGHT_BITS-1:0] wt, input logic fin);
      send_request(ACT_WEIGHT, 4'($urandom), 8'($urandom), wt, fin);
   endtask

   // values drawn mostly from a small set so transitions repeat
   function automatic logic [VALUE_BITS-1:0] random_value();
      if ($urandom_range(99) < 60) begin
         return 4'(5 * $urandom_range(3));
      end
      return 4'($urandom);
   endfunction

   // half the reads aim at pairs leaving the latest sampled value
   function automatic logic [INDEX_BITS-1:0] random_index();
      if ($urandom_range(1) == 1) begin
         return {last_sampled, random_value()};
      end
      return 8'($urandom);
   endfunction

   function automatic logic signed [WEIGHT_BITS-1:0] random_weight();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return 16'sh8000;
      end
      if (pick < 16) begin
         return 16'sh7FFF;
      end
      if (pick < 20) begin
         return 16'sh0000;
      end
      return 16'($urandom);
   endfunction

   // weight walk of a given length, with samples and reads slipped in
   task automatic weight_walk(input int unsigned span);
      for (int k = 1; k <= span; k++) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(1) == 1) begin
               sample_signals(random_value());
            end else begin
               read_counter(random_index());
            end
         end
         apply_weight(random_weight(), k == span);
      end
   endtask

   // one random burst of activity
   task automatic run_burst();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         repeat ($urandom_range(12, 1)) sample_signals(random_value());
      end else if (pick < 62) begin
         repeat ($urandom_range(3, 1)) read_counter(random_index());
      end else if (pick < 96) begin
         weight_walk($urandom_range(24, 1));
      end else begin
         send_request(ACT_UNUSED, 4'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   // stimulus and verdict
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_SAMPLE;
      req_bus.signal_value = '0;
      req_bus.read_index   = '0;
      req_bus.weight       = '0;
      req_bus.last         = 1'b0;
      rsp_bus.ready        = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      phase_items  = 0;
      last_sampled = '0;
      squeeze      = 1'b0;
      reset        = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store, then the corner transitions, first one leaving zero
      read_counter(8'h00);
      read_counter(8'hFF);
      sample_signals(4'h0);
      sample_signals(4'hF);
      sample_signals(4'hF);
      sample_signals(4'h0);
      sample_signals(4'h5);
      sample_signals(4'hA);
      read_counter(8'h00);
      read_counter(8'h0F);
      read_counter(8'hFF);
      read_counter(8'hF0);
      read_counter(8'h5A);
      // unused action code with every field at both extremes
      send_request(ACT_UNUSED, 4'hF, 8'hFF, 16'shFFFF, 1'b1);
      send_request(ACT_UNUSED, 4'h0, 8'h00, 16'sh0000, 1'b0);
      // extreme weights, a walk of one, then a walk with mixed actions
      apply_weight(16'sh8000, 1'b0);
      apply_weight(16'sh7FFF, 1'b0);
      apply_weight(16'sh0001, 1'b1);
      apply_weight(16'sh7FFF, 1'b1);
      apply_weight(16'shFF00, 1'b0);
      sample_signals(4'h0);
      read_counter(8'h00);
      apply_weight(16'sh0100, 1'b1);

      // random phases with differing idle and stall patterns
      for (int p = 0; p < 4; p++) begin
         idle_pct    = idle_plan[p];
         stall_pct   = stall_plan[p];
         phase_items = 0;
         if (p == 0) begin
            squeeze = 1'b1;
            repeat (40) read_counter(random_index());
         end
         if (p == 3) begin
            // walk past the end of the store so the pointer wraps
            weight_walk($urandom_range(270, 257));
         end
         while (phase_items < PHASE_ITEMS) begin
            run_burst();
         end
      end
      req_bus.valid <= 1'b0;

      // drain
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("signal_transition_histogram_tb: clean");
      end else begin
         $display("signal_transition_histogram_tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/sth_pkg.sv
hdl/sth_if.sv
hdl/sth_ram.sv
hdl/sth_ctrl.sv
hdl/sth_datapath.sv
hdl/signal_transition_histogram.sv
verif/transition_histogram_checker.sv
verif/signal_transition_histogram_tb.sv
